// ===== sv/wwge_pkg.sv =====
// Package with the cell codes, command codes, sequencer states and cell rules of the grid engine.
`timescale 1ns / 1ps
`default_nettype none

package wwge_pkg;

	localparam int unsigned MAX_COLS_DEF = 64;
	localparam int unsigned MAX_ROWS_DEF = 64;

	localparam int unsigned OPCODE_W  = 3;
	localparam int unsigned COORD_W   = 6;
	localparam int unsigned CELL_W    = 2;
	localparam int unsigned DIM_W     = 7;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	typedef enum logic [CELL_W-1:0] {
		CELL_EMPTY = 2'd0,
		CELL_HEAD  = 2'd1,
		CELL_TAIL  = 2'd2,
		CELL_COND  = 2'd3
	} cell_t;

	typedef enum logic [OPCODE_W-1:0] {
		OP_WRITE = 3'd0,
		OP_CYCLE = 3'd1,
		OP_CLEAR = 3'd2,
		OP_STEP  = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_MODIFY,
		S_STEP,
		S_REPLY
	} state_t;

	// One column of the 3 by 3 neighborhood window.
	typedef struct packed {
		cell_t up;
		cell_t mid;
		cell_t dn;
	} col3_t;

	// Line buffer entry: old values of the two rows above the incoming row.
	typedef struct packed {
		cell_t prev;
		cell_t cur;
	} lb_pair_t;

	function automatic cell_t ww_cycle(cell_t c);
		cell_t r;
		unique case (c)
			CELL_EMPTY: r = CELL_HEAD;
			CELL_HEAD:  r = CELL_TAIL;
			CELL_TAIL:  r = CELL_COND;
			CELL_COND:  r = CELL_HEAD;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] ww_heads(col3_t l, col3_t c, col3_t r);
		logic [3:0] n;
		n = 4'(l.up == CELL_HEAD) + 4'(l.mid == CELL_HEAD) + 4'(l.dn == CELL_HEAD)
			+ 4'(c.up == CELL_HEAD) + 4'(c.dn == CELL_HEAD)
			+ 4'(r.up == CELL_HEAD) + 4'(r.mid == CELL_HEAD) + 4'(r.dn == CELL_HEAD);
		return n;
	endfunction

	function automatic cell_t ww_next(cell_t c, logic [3:0] heads);
		cell_t r;
		unique case (c)
			CELL_EMPTY: r = CELL_EMPTY;
			CELL_HEAD:  r = CELL_TAIL;
			CELL_TAIL:  r = CELL_COND;
			CELL_COND:  r = (heads == 4'd1 || heads == 4'd2) ? CELL_HEAD : CELL_COND;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/wireworld_grid_engine.sv =====
// Top level of the grid engine: cell store, line buffer, step sequencer and command handling.
//
//  channel   direction  handshake               payload
//  in        to block   in_valid / in_stall     opcode, cell_col, cell_row, cell_value
//  out       from block out_valid / out_stall   cell_state, out_of_range
//  cfg       to block   cfg_we                  cfg_index, cfg_data
//
// A write, cycle or read command reads the store in S_READ and gives its result from S_MODIFY; an
// ignored command replies from S_REPLY. In a step the neighborhood unit handles one cell per cycle
// through the single read port of the cell store, plus one priming row and one edge beat per row.
// A clear and the clearing pass after reset empty all MAX_ROWS * MAX_COLS store entries (dimensions
// rounded up to powers of two), one store entry per cycle; no command is taken during the pass after
// reset.
// A new command is taken while a result still waits under out_stall.
`timescale 1ns / 1ps
`default_nettype none

module wireworld_grid_engine #(
	parameter int unsigned MAX_COLS = wwge_pkg::MAX_COLS_DEF,
	parameter int unsigned MAX_ROWS = wwge_pkg::MAX_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [wwge_pkg::OPCODE_W-1:0]    opcode,
	input  logic [wwge_pkg::COORD_W-1:0]     cell_col,
	input  logic [wwge_pkg::COORD_W-1:0]     cell_row,
	input  logic [wwge_pkg::CELL_W-1:0]      cell_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [wwge_pkg::CELL_W-1:0]      cell_state,
	output logic                             out_of_range,
	input  logic                             cfg_we,
	input  logic [wwge_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wwge_pkg::DIM_W-1:0]       cfg_data
);

	import wwge_pkg::*;

	localparam int unsigned CW    = $clog2(MAX_COLS);
	localparam int unsigned RW    = $clog2(MAX_ROWS);
	localparam int unsigned AW    = CW + RW;
	localparam int unsigned DEPTH = 2 ** AW;
	localparam int unsigned ECW   = $clog2(MAX_COLS + 1);
	localparam int unsigned ERW   = $clog2(MAX_ROWS + 1);

	localparam col3_t COL_EMPTY = '{up: CELL_EMPTY, mid: CELL_EMPTY, dn: CELL_EMPTY};

	cell_t    cell_mem [DEPTH];
	lb_pair_t lb_mem [MAX_COLS];

	state_t state_q, state_d;

	logic [DIM_W-1:0] grid_width_q, grid_height_q;
	logic [ECW-1:0]   eff_cols;
	logic [ERW-1:0]   eff_rows;

	logic [OPCODE_W-1:0] cmd_op_q;
	logic [CW-1:0]       cmd_col_q;
	logic [RW-1:0]       cmd_row_q;
	cell_t               cmd_val_q;
	logic                res_oor_q;
	logic                clr_reply_q;
	logic [AW-1:0]       clr_cnt_q;

	logic [ERW-1:0] rr_q;
	logic [ECW-1:0] k_q;
	logic           v_s1, fetch_s1;
	logic [ERW-1:0] rr_s1;
	logic [ECW-1:0] k_s1;
	col3_t          win_l_q, win_c_q, col_new;

	logic out_valid_q, out_oor_q;
	cell_t out_state_q;

	cell_t    mem_rd_q;
	lb_pair_t lb_rd_q;

	logic          accept, in_ready, is_cell_op, in_oor;
	logic          step_issue, issue_fetch, issue_last;
	logic          clr_we, rmw_we, step_we, out_load, out_free, mem_we, lb_we;
	cell_t         res_state, step_new, mem_wd;
	logic [AW-1:0] mem_ra, mem_wa, cmd_addr, step_wa;
	logic [CW-1:0] lb_ra, lb_wa;
	logic [ERW-1:0] wr_row_e;
	logic [ECW-1:0] wr_col_e;

	assign eff_cols = (int'(grid_width_q) > MAX_COLS) ? ECW'(MAX_COLS) : ECW'(grid_width_q);
	assign eff_rows = (int'(grid_height_q) > MAX_ROWS) ? ERW'(MAX_ROWS) : ERW'(grid_height_q);

	assign is_cell_op = (opcode == OP_WRITE) || (opcode == OP_CYCLE) || (opcode == OP_READ);
	assign in_oor     = (int'(cell_col) >= int'(eff_cols)) || (int'(cell_row) >= int'(eff_rows));
	assign in_stall   = !in_ready;
	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || !out_stall;

	assign issue_last  = (rr_q == eff_rows) && (k_q == eff_cols);
	assign issue_fetch = step_issue && (k_q != eff_cols);
	assign cmd_addr    = {cmd_row_q, cmd_col_q};

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		clr_we     = 1'b0;
		rmw_we     = 1'b0;
		out_load   = 1'b0;
		step_issue = 1'b0;
		res_state  = CELL_EMPTY;
		unique case (state_q)
			S_CLEAR: begin
				clr_we = 1'b1;
				if (clr_cnt_q == '1) begin
					state_d = clr_reply_q ? S_REPLY : S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					priority if (opcode == OP_CLEAR) begin
						state_d = S_CLEAR;
					end else if (opcode == OP_STEP) begin
						state_d = (eff_cols == '0 || eff_rows == '0) ? S_REPLY : S_STEP;
					end else if (is_cell_op && !in_oor) begin
						state_d = S_READ;
					end else begin
						state_d = S_REPLY;
					end
				end
			end
			S_READ: begin
				state_d = S_MODIFY;
			end
			S_MODIFY: begin
				unique case (cmd_op_q)
					OP_WRITE: res_state = cmd_val_q;
					OP_CYCLE: res_state = ww_cycle(mem_rd_q);
					default:  res_state = mem_rd_q;
				endcase
				if (out_free) begin
					out_load = 1'b1;
					rmw_we   = (cmd_op_q == OP_WRITE) || (cmd_op_q == OP_CYCLE);
					state_d  = S_IDLE;
				end
			end
			S_STEP: begin
				step_issue = 1'b1;
				if (issue_last) begin
					state_d = S_REPLY;
				end
			end
			S_REPLY: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_cnt_q     <= '0;
			clr_reply_q   <= 1'b0;
			rr_q          <= '0;
			k_q           <= '0;
			v_s1          <= 1'b0;
			fetch_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			grid_width_q  <= DIM_RESET;
			grid_height_q <= DIM_RESET;
		end else begin
			state_q  <= state_d;
			v_s1     <= step_issue;
			fetch_s1 <= issue_fetch;
			if (clr_we) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (accept) begin
				clr_reply_q <= (opcode == OP_CLEAR);
			end
			if (step_issue) begin
				if (k_q == eff_cols) begin
					k_q  <= '0;
					rr_q <= issue_last ? '0 : rr_q + ERW'(1);
				end else begin
					k_q <= k_q + ECW'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
					REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_op_q  <= opcode;
			cmd_col_q <= CW'(cell_col);
			cmd_row_q <= RW'(cell_row);
			cmd_val_q <= cell_t'(cell_value);
			res_oor_q <= is_cell_op && in_oor;
		end
		if (out_load) begin
			out_state_q <= res_state;
			out_oor_q   <= res_oor_q;
		end
		rr_s1 <= rr_q;
		k_s1  <= k_q;
		if (v_s1) begin
			if (k_s1 == '0) begin
				win_l_q <= COL_EMPTY;
			end else begin
				win_l_q <= win_c_q;
			end
			win_c_q <= col_new;
		end
	end

	// The incoming column: old rows r-1 and r from the line buffer, old row r+1 from the store.
	always_comb begin
		col_new.up  = (fetch_s1 && int'(rr_s1) >= 2) ? lb_rd_q.prev : CELL_EMPTY;
		col_new.mid = (fetch_s1 && int'(rr_s1) >= 1) ? lb_rd_q.cur : CELL_EMPTY;
		col_new.dn  = (fetch_s1 && rr_s1 < eff_rows) ? mem_rd_q : CELL_EMPTY;
	end

	assign wr_row_e = rr_s1 - ERW'(1);
	assign wr_col_e = k_s1 - ECW'(1);
	assign step_we  = v_s1 && (k_s1 != '0) && (rr_s1 != '0);
	assign step_wa  = {wr_row_e[RW-1:0], wr_col_e[CW-1:0]};
	assign step_new = ww_next(win_c_q.mid, ww_heads(win_l_q, win_c_q, col_new));

	assign lb_ra = k_q[CW-1:0];
	assign lb_wa = k_s1[CW-1:0];
	assign lb_we = v_s1 && fetch_s1;

	always_ff @(posedge clk) begin
		lb_rd_q <= lb_mem[lb_ra];
		if (lb_we) begin
			lb_mem[lb_wa] <= '{prev: col_new.mid, cur: col_new.dn};
		end
	end

	assign mem_ra = step_issue ? {rr_q[RW-1:0], k_q[CW-1:0]} : cmd_addr;
	assign mem_we = step_we || clr_we || rmw_we;

	always_comb begin
		priority if (step_we) begin
			mem_wa = step_wa;
			mem_wd = step_new;
		end else if (clr_we) begin
			mem_wa = clr_cnt_q;
			mem_wd = CELL_EMPTY;
		end else begin
			mem_wa = cmd_addr;
			mem_wd = res_state;
		end
	end

	always_ff @(posedge clk) begin
		mem_rd_q <= cell_mem[mem_ra];
		if (mem_we) begin
			cell_mem[mem_wa] <= mem_wd;
		end
	end

	assign out_valid    = out_valid_q;
	assign cell_state   = out_state_q;
	assign out_of_range = out_oor_q;

	a_step_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		step_we |-> (wr_row_e < eff_rows) && (wr_col_e < eff_cols))
		else $error("step write outside the configured grid");

	a_lb_no_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		issue_fetch && lb_we |-> lb_ra != lb_wa)
		else $error("line buffer read and write at the same entry");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		step_we |-> !clr_we && !rmw_we)
		else $error("step write collides with another store write");

	a_oor_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> cell_state == CELL_EMPTY)
		else $error("out of range result carries a cell state");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_MODIFY || $past(state_q) == S_REPLY)
		else $error("result raised outside a reply state");

endmodule

`default_nettype wire

// ===== bench/wireworld_grid_engine_checker.sv =====
// Checker for the grid engine: tracks the grid, predicts every result and compares it.
`timescale 1ns / 1ps

module wireworld_grid_engine_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [wwge_pkg::OPCODE_W-1:0]   opcode,
	input  logic [wwge_pkg::COORD_W-1:0]    cell_col,
	input  logic [wwge_pkg::COORD_W-1:0]    cell_row,
	input  logic [wwge_pkg::CELL_W-1:0]     cell_value,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [wwge_pkg::CELL_W-1:0]     cell_state,
	input  logic                            out_of_range,
	input  logic                            cfg_we,
	input  logic [wwge_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wwge_pkg::DIM_W-1:0]      cfg_data,
	output int                              errors,
	output int                              checked,
	output int                              pending
);

	import wwge_pkg::*;

	localparam int COLS = MAX_COLS_DEF;
	localparam int ROWS = MAX_ROWS_DEF;

	typedef struct packed {
		cell_t state;
		logic  oor;
	} reply_t;

	cell_t            board [ROWS][COLS];
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	reply_t           replies_due [$];
	int               error_count = 0;
	int               checked_count = 0;
	int               pending_q = 0;

	assign errors  = error_count;
	assign checked = checked_count;
	assign pending = pending_q;

	function automatic int live_cols();
		return (width_reg > COLS) ? COLS : int'(width_reg);
	endfunction

	function automatic int live_rows();
		return (height_reg > ROWS) ? ROWS : int'(height_reg);
	endfunction

	// Every cell inside the grid moves at once, so all neighbors are read from a snapshot.
	function automatic void advance_generation();
		cell_t prior [ROWS][COLS];
		int    cols, rows, heads, r, c, dr, dc, nr, nc;
		cols = live_cols();
		rows = live_rows();
		prior = board;
		for (r = 0; r < rows; r++) begin
			for (c = 0; c < cols; c++) begin
				case (prior[r][c])
					CELL_HEAD: board[r][c] = CELL_TAIL;
					CELL_TAIL: board[r][c] = CELL_COND;
					CELL_COND: begin
						heads = 0;
						for (dr = -1; dr <= 1; dr++) begin
							for (dc = -1; dc <= 1; dc++) begin
								nr = r + dr;
								nc = c + dc;
								if ((dr != 0 || dc != 0) && nr >= 0 && nr < rows && nc >= 0
										&& nc < cols && prior[nr][nc] == CELL_HEAD)
									heads++;
							end
						end
						if (heads == 1 || heads == 2)
							board[r][c] = CELL_HEAD;
					end
					default: ;
				endcase
			end
		end
	endfunction

	function automatic reply_t apply_command(logic [OPCODE_W-1:0] op, logic [COORD_W-1:0] col,
			logic [COORD_W-1:0] row, logic [CELL_W-1:0] val);
		reply_t rep;
		rep = '{CELL_EMPTY, 1'b0};
		case (op)
			OP_CLEAR: foreach (board[r, c]) board[r][c] = CELL_EMPTY;
			OP_STEP:  advance_generation();
			OP_WRITE, OP_CYCLE, OP_READ: begin
				if (col >= live_cols() || row >= live_rows()) begin
					rep.oor = 1'b1;
				end else begin
					if (op == OP_WRITE) begin
						board[row][col] = cell_t'(val);
					end else if (op == OP_CYCLE) begin
						case (board[row][col])
							CELL_EMPTY, CELL_COND: board[row][col] = CELL_HEAD;
							CELL_HEAD:             board[row][col] = CELL_TAIL;
							default:               board[row][col] = CELL_COND;
						endcase
					end
					rep.state = board[row][col];
				end
			end
			default: ;
		endcase
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		reply_t want;
		if (!arst_n) begin
			foreach (board[r, c]) board[r][c] = CELL_EMPTY;
			width_reg = DIM_RESET;
			height_reg = DIM_RESET;
			replies_due.delete();
			pending_q <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_GRID_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == REG_GRID_HEIGHT)
					height_reg = cfg_data;
			end
			if (in_valid && !in_stall)
				replies_due.push_back(apply_command(opcode, cell_col, cell_row, cell_value));
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					error_count++;
					$display("%0t ns: unexpected result transfer: cell_state %0d",
						$time, cell_state);
					$display("%0t ns: unexpected result transfer: out_of_range %0d",
						$time, out_of_range);
				end else begin
					want = replies_due.pop_front();
					checked_count++;
					if (cell_state !== want.state) begin
						error_count++;
						$display("%0t ns: cell_state expected %0d, got %0d",
							$time, want.state, cell_state);
					end
					if (out_of_range !== want.oor) begin
						error_count++;
						$display("%0t ns: out_of_range expected %0d, got %0d",
							$time, want.oor, out_of_range);
					end
				end
			end
			pending_q <= replies_due.size();
		end
	end

endmodule

// ===== bench/wireworld_grid_engine_tb.sv =====
// Testbench top for the grid engine: clock, reset, command and register stimulus, and the verdict.
`timescale 1ns / 1ps

module wireworld_grid_engine_tb;
	import wwge_pkg::*;

	localparam int STALL_LIMIT = 25000;
	localparam int SETTLE_CYCLES = 8;
	localparam int COORD_MAX = (1 << COORD_W) - 1;
	localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SPARE_LAST = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [OPCODE_W-1:0]  opcode;
	logic [COORD_W-1:0]   cell_col;
	logic [COORD_W-1:0]   cell_row;
	logic [CELL_W-1:0]    cell_value;
	logic                 out_valid;
	logic                 out_stall;
	logic [CELL_W-1:0]    cell_state;
	logic                 out_of_range;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	int error_count, checked_count, pending_count;
	int burst_left, idle_cycles, stall_mode, stall_left;
	int sent_count, step_count, clear_count, shape_count;
	int win_col0, win_row0, win_cols, win_rows;

	wireworld_grid_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .cell_col(cell_col), .cell_row(cell_row), .cell_value(cell_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.cell_state(cell_state), .out_of_range(out_of_range),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	wireworld_grid_engine_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .cell_col(cell_col), .cell_row(cell_row), .cell_value(cell_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.cell_state(cell_state), .out_of_range(out_of_range),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(error_count), .checked(checked_count), .pending(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		stall_mode = 0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 200);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 2) == 0);
				2:       out_stall <= ((stall_left % 5) < 3);
				default: out_stall <= ($urandom_range(0, 1) == 1);
			endcase
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Stopped after %0d cycles without a transfer.", STALL_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic issue(input logic [OPCODE_W-1:0] op, input logic [COORD_W-1:0] col,
			input logic [COORD_W-1:0] row, input logic [CELL_W-1:0] val);
		int gap;
		in_valid <= 1'b1;
		opcode <= op;
		cell_col <= col;
		cell_row <= row;
		cell_value <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
		if (op == OP_STEP)
			step_count++;
		if (op == OP_CLEAR)
			clear_count++;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 7);
			repeat (gap) @(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(15, 40);
			else
				burst_left = $urandom_range(0, 6);
		end else begin
			burst_left--;
		end
	endtask

	// Wait until every result is back before the grid shape may change.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		int live_w, live_h;
		cfg_we <= 1'b1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		shape_count++;
		live_w = (w > MAX_COLS_DEF) ? MAX_COLS_DEF : w;
		live_h = (h > MAX_ROWS_DEF) ? MAX_ROWS_DEF : h;
		win_cols = (live_w < 6) ? live_w : 6;
		win_rows = (live_h < 6) ? live_h : 6;
		win_col0 = $urandom_range(0, live_w - win_cols);
		win_row0 = $urandom_range(0, live_h - win_rows);
	endtask

	// Addresses mostly fall in a small window so that wires and heads meet.
	function automatic logic [COORD_W-1:0] pick_coord(int base, int span);
		if (span == 0 || $urandom_range(0, 99) < 15)
			return COORD_W'($urandom_range(0, COORD_MAX));
		return COORD_W'(base + int'($urandom_range(0, span - 1)));
	endfunction

	task automatic random_command();
		int                  pick;
		logic [OPCODE_W-1:0] op;
		logic [CELL_W-1:0]   val;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			op = OP_WRITE;
		else if (pick < 50)
			op = OP_CYCLE;
		else if (pick < 70)
			op = OP_READ;
		else if (pick < 90)
			op = OP_STEP;
		else if (pick < 93)
			op = OP_CLEAR;
		else
			op = OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		pick = $urandom_range(0, 99);
		if (pick < 50)
			val = CELL_COND;
		else if (pick < 70)
			val = CELL_HEAD;
		else if (pick < 80)
			val = CELL_TAIL;
		else if (pick < 90)
			val = CELL_EMPTY;
		else
			val = CELL_W'($urandom_range(0, 3));
		issue(op, pick_coord(win_col0, win_cols), pick_coord(win_row0, win_rows), val);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_READ;
		cell_col = '0;
		cell_row = '0;
		cell_value = CELL_EMPTY;
		cfg_we = 1'b0;
		cfg_index = REG_GRID_WIDTH;
		cfg_data = DIM_RESET;
		burst_left = 0;
		sent_count = 0;
		step_count = 0;
		clear_count = 0;
		shape_count = 0;
		win_col0 = 0;
		win_row0 = 0;
		win_cols = 0;
		win_rows = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset shape: the grid must come up empty and steps must span the full store.
		issue(OP_READ, 0, 0, CELL_EMPTY);
		issue(OP_WRITE, 63, 63, CELL_COND);
		issue(OP_WRITE, 62, 63, CELL_COND);
		issue(OP_CYCLE, 63, 63, CELL_EMPTY);
		issue(OP_CYCLE, 0, 0, CELL_EMPTY);
		issue(OP_WRITE, 1, 0, CELL_COND);
		issue(OP_WRITE, 10, 10, CELL_COND);
		issue(OP_WRITE, 9, 9, CELL_HEAD);
		issue(OP_WRITE, 10, 9, CELL_HEAD);
		issue(OP_WRITE, 11, 9, CELL_HEAD);
		issue(OP_WRITE, 61, 62, CELL_COND);
		issue(OP_STEP, 0, 0, CELL_EMPTY);
		issue(OP_READ, 62, 63, CELL_EMPTY);
		issue(OP_READ, 10, 10, CELL_EMPTY);
		issue(OP_STEP, 63, 63, CELL_COND);
		issue(OP_READ, 61, 62, CELL_EMPTY);
		issue(OP_CYCLE, 63, 63, CELL_EMPTY);
		issue(OP_CYCLE, 63, 63, CELL_EMPTY);
		issue(OP_CYCLE, 63, 63, CELL_EMPTY);
		issue(OP_WRITE, 5, 40, CELL_TAIL);
		issue(OP_WRITE, 40, 5, CELL_EMPTY);
		issue(OP_SPARE_FIRST, 63, 0, CELL_COND);
		issue(OP_SPARE_FIRST + 3'd1, 0, 63, CELL_HEAD);
		issue(OP_SPARE_LAST, 63, 63, CELL_COND);
		issue(OP_CLEAR, 0, 0, CELL_EMPTY);
		issue(OP_READ, 63, 63, CELL_EMPTY);
		settle();

		// Saturated width with zero height: no cell exists.
		set_grid(7'd127, 7'd0);
		issue(OP_READ, 0, 0, CELL_EMPTY);
		issue(OP_STEP, 0, 0, CELL_EMPTY);
		issue(OP_WRITE, 63, 0, CELL_COND);
		settle();

		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0:       set_grid(7'd1, 7'd1);
				1:       set_grid(7'd64, 7'd2);
				2:       set_grid(7'd2, 7'd64);
				3:       set_grid(7'd127, 7'd4);
				4:       set_grid(7'd0, DIM_W'($urandom_range(1, 64)));
				8:       set_grid(7'd64, 7'd64);
				default: set_grid(DIM_W'($urandom_range(3, 9)), DIM_W'($urandom_range(3, 9)));
			endcase
			repeat ((phase == 4) ? 6 : 14) random_command();
			settle();
		end

		$display("Covered %0d commands (%0d steps, %0d clears) over %0d grid shapes.",
			sent_count, step_count, clear_count, shape_count);
		$display("Compared %0d results against the tracked grid.", checked_count);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/wwge_pkg.sv
sv/wireworld_grid_engine.sv
bench/wireworld_grid_engine_checker.sv
bench/wireworld_grid_engine_tb.sv
